// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/ahpp_pkg.sv =====
package ahpp_pkg;

  localparam logic [1:0] KIND_ADDR = 2'd0;
  localparam logic [1:0] KIND_ID   = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic [1:0] MODE_HEX  = 2'd0;
  localparam logic [1:0] MODE_RAW  = 2'd1;
  localparam logic [1:0] MODE_NONE = 2'd2;

  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [7:0] CHAR_X = 8'h58;
  localparam logic [7:0] CHAR_S = 8'h53;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] packet_type;
    logic       digit_error;
    logic       last;
  } result_t;

  function automatic logic hex_valid(input logic [7:0] c);
    hex_valid = ((c >= CHAR_0) && (c <= CHAR_9)) || ((c >= CHAR_A) && (c <= CHAR_F));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if ((c >= CHAR_0) && (c <= CHAR_9)) begin
      hex_nibble = c[3:0];
    end else if ((c >= CHAR_A) && (c <= CHAR_F)) begin
      hex_nibble = c[3:0] + 4'd9;
    end else begin
      hex_nibble = 4'd0;
    end
  endfunction

endpackage

// ===== rtl/core/ascii_hex_packet_parser.sv =====
// Parses an ASCII packet arriving one byte per word on the slave side and
// streams address, id, data and end-status words on the master side. The
// parser takes one byte every cycle; each byte is decoded in the cycle it is
// accepted and its zero, one or two results go into a DEPTH-entry output
// queue, which drains one word per cycle while m_tready is high. The slave
// side stalls only while fewer than two entries are free, so with m_tready
// high a packet whose bytes yield at most one word each runs at one byte per cycle.
`include "assert_macros.svh"

module ascii_hex_packet_parser #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic        s_tlast,   // end_of_packet
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // value[7:0], packet_type[9:8], digit_error[10], zero[15:11]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast    // last
);
  import ahpp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_ROOM = CW'(DEPTH - 2);

  logic [2:0] byte_position, byte_position_next;
  logic [1:0] data_mode, data_mode_next;
  logic [7:0] delay0, delay0_next, delay1, delay1_next;
  logic [1:0] delay_fill, delay_fill_next;
  logic [3:0] high_digit, high_digit_next;
  logic       high_digit_held, high_digit_held_next;
  logic       packet_error, packet_error_next;

  result_t       queue [DEPTH];
  logic [AW-1:0] wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next;
  logic [CW-1:0] count, count_next;

  logic    s_acc, m_acc;
  logic    res_valid, end_valid;
  result_t res_word, end_word;
  logic [AW-1:0] wr_ptr_plus, end_addr;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;
  assign s_tready = (count <= CNT_ROOM);

  always_comb begin
    logic [7:0] digit_byte;
    logic [3:0] nib;
    logic       use_digit;
    byte_position_next   = byte_position;
    data_mode_next       = data_mode;
    delay0_next          = delay0;
    delay1_next          = delay1;
    delay_fill_next      = delay_fill;
    high_digit_next      = high_digit;
    high_digit_held_next = high_digit_held;
    packet_error_next    = packet_error;
    res_valid            = 1'b0;
    res_word             = '0;
    end_word             = '0;
    use_digit            = 1'b0;
    digit_byte           = (byte_position >= 3'd6) ? delay0 : s_tdata;
    nib                  = hex_nibble(digit_byte);

    if (byte_position == 3'd1) begin
      if (s_tdata == CHAR_X) begin
        data_mode_next = MODE_HEX;
      end else if (s_tdata == CHAR_S) begin
        data_mode_next = MODE_RAW;
      end else begin
        data_mode_next = MODE_NONE;
      end
    end else if ((byte_position >= 3'd2) && (byte_position <= 3'd5)) begin
      use_digit = 1'b1;
      res_word.kind = (byte_position == 3'd3) ? KIND_ADDR : KIND_ID;
    end else if (byte_position >= 3'd6) begin
      if (delay_fill >= 2'd2) begin
        delay0_next = delay1;
        delay1_next = s_tdata;
        res_word.kind = KIND_DATA;
        if (data_mode == MODE_RAW) begin
          res_valid = 1'b1;
          res_word.value = delay0;
        end else if (data_mode == MODE_HEX) begin
          use_digit = 1'b1;
        end
      end else begin
        if (delay_fill[0]) begin
          delay1_next = s_tdata;
        end else begin
          delay0_next = s_tdata;
        end
        delay_fill_next = delay_fill + 2'd1;
      end
    end

    if (use_digit) begin
      if (!hex_valid(digit_byte)) begin
        packet_error_next = 1'b1;
      end
      if (!high_digit_held) begin
        high_digit_next      = nib;
        high_digit_held_next = 1'b1;
      end else begin
        res_valid            = 1'b1;
        res_word.value       = {high_digit, nib};
        high_digit_next      = 4'd0;
        high_digit_held_next = 1'b0;
      end
    end

    res_word.packet_type = data_mode_next;
    res_word.digit_error = packet_error_next;

    if (byte_position != 3'd7) begin
      byte_position_next = byte_position + 3'd1;
    end

    end_valid            = s_tlast;
    end_word.kind        = KIND_END;
    end_word.packet_type = data_mode_next;
    end_word.last        = 1'b1;
    end_word.digit_error = packet_error_next || (byte_position < 3'd5) ||
                           ((data_mode_next == MODE_HEX) && (byte_position >= 3'd6) &&
                            high_digit_held_next);
    if (s_tlast) begin
      byte_position_next   = 3'd0;
      data_mode_next       = MODE_NONE;
      delay0_next          = 8'd0;
      delay1_next          = 8'd0;
      delay_fill_next      = 2'd0;
      high_digit_next      = 4'd0;
      high_digit_held_next = 1'b0;
      packet_error_next    = 1'b0;
    end
  end

  assign wr_ptr_plus = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
  assign end_addr    = res_valid ? wr_ptr_plus : wr_ptr;

  always_comb begin
    logic [AW-1:0] end_plus;
    end_plus    = (end_addr == PTR_LAST) ? '0 : end_addr + AW'(1);
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (s_acc) begin
      wr_ptr_next = end_valid ? end_plus : end_addr;
      count_next  = count + CW'(res_valid) + CW'(end_valid);
    end
    if (m_acc) begin
      rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + AW'(1);
      count_next  = count_next - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 3'd0;
      data_mode       <= MODE_NONE;
      delay0          <= 8'd0;
      delay1          <= 8'd0;
      delay_fill      <= 2'd0;
      high_digit      <= 4'd0;
      high_digit_held <= 1'b0;
      packet_error    <= 1'b0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      if (s_acc) begin
        byte_position   <= byte_position_next;
        data_mode       <= data_mode_next;
        delay0          <= delay0_next;
        delay1          <= delay1_next;
        delay_fill      <= delay_fill_next;
        high_digit      <= high_digit_next;
        high_digit_held <= high_digit_held_next;
        packet_error    <= packet_error_next;
      end
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && res_valid) begin
      queue[wr_ptr] <= res_word;
    end
    if (s_acc && end_valid) begin
      queue[end_addr] <= end_word;
    end
  end

  assign m_tvalid = (count != '0);
  assign m_tdata  = {5'd0, queue[rd_ptr].digit_error, queue[rd_ptr].packet_type,
                     queue[rd_ptr].value};
  assign m_tuser  = queue[rd_ptr].kind;
  assign m_tlast  = queue[rd_ptr].last;

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `ASSERT_ALWAYS(a_held_after_mode, clk, rst, !high_digit_held || (byte_position >= 3'd3))
  `ASSERT_NEXT(a_restart_on_last, clk, rst, s_acc && s_tlast, byte_position == 3'd0)
  `ASSERT_NEXT(a_last_queues_word, clk, rst, s_acc && s_tlast, m_tvalid)

endmodule
